>>> rtl/ftrsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slot allocator package
// Shared widths, result codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ftrsa_pkg;

    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;

    // Item kinds on the request channel.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_MARK  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_GRANTED   = 2'd0,
        STATUS_NONE_FREE = 2'd1,
        STATUS_MARK_SET  = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic mark_wr;
        logic fill_grant;
        logic walk_start;
        logic walk_step;
        logic unlink;
        logic append;
        logic load_grant;
        logic load_fail;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic fill_left;
        logic cur_free;
        logic cur_is_tail;
    } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/ftrsa_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Carries one request word: an allocation or a busy mark update.
// ----------------------------------------------------------------------------
interface ftrsa_req_if import ftrsa_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              kind;
    logic [SLOT_W-1:0] slot_index;
    logic              busy_value;

    modport source (output valid, kind, slot_index, busy_value, input ready);
    modport sink   (input valid, kind, slot_index, busy_value, output ready);

endinterface
`default_nettype wire

>>> rtl/ftrsa_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Carries one response word per request.
// ----------------------------------------------------------------------------
interface ftrsa_rsp_if import ftrsa_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
    logic                contents_lost;

    modport source (output valid, status, granted_slot, contents_lost, input ready);
    modport sink   (input valid, status, granted_slot, contents_lost, output ready);

endinterface
`default_nettype wire

>>> rtl/fill_then_reuse_slot_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fill-then-reuse slot allocator
// A busy mark word or a fill-mode allocation answers in the cycle after
// acceptance; a reuse allocation answers once the walk stops at a free slot
// or at the tail, after a further unlink step and append step when that slot
// has to be relinked at the tail.
// The reuse walk visits one list slot per cycle through the link memory read
// port; the next request is taken once the current word is answered.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes every
// busy mark while req.ready is held low.
// ----------------------------------------------------------------------------
//
// The slots are kept in a singly linked list in the order they were handed
// out. While unused slots remain, each allocation takes the next one and
// appends it at the tail. Once every slot has been handed out, the block
// stays in reuse mode: it walks from the head to the first slot whose busy
// mark is clear, moves that slot to the tail and grants it, flagging that its
// old contents are gone. When no busy mark along the list is clear, the word
// reports that no slot could be reused and the list is left as it was.
//
// The controller and the datapath are joined only by a command bundle and a
// status bundle. The response register sits in the datapath, with its valid
// flag in the controller; while a finished word waits on the response
// channel, the request channel is not ready.
module fill_then_reuse_slot_allocator import ftrsa_pkg::*; #(
    parameter int ENTRIES = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ftrsa_req_if.sink   req,
    ftrsa_rsp_if.source rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller decides, from the request kind and the datapath status,
    // which single step runs in each cycle.
    ftrsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // The datapath holds the list, the busy marks and the response payload.
    ftrsa_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .slot_index    (req.slot_index),
        .busy_value    (req.busy_value),
        .status        (rsp.status),
        .granted_slot  (rsp.granted_slot),
        .contents_lost (rsp.contents_lost)
    );

endmodule
`default_nettype wire

>>> rtl/ftrsa_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slot allocator datapath
// Holds the link and busy memories, the list pointers, the walk cursor and
// the response register.
// ----------------------------------------------------------------------------
module ftrsa_dp import ftrsa_pkg::*; #(
    parameter int ENTRIES = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dp_cmd_t             cmd,
    output dp_stat_t                 stat,
    input  wire logic [SLOT_W-1:0]   slot_index,
    input  wire logic                busy_value,
    output logic [STATUS_W-1:0]      status,
    output logic [SLOT_W-1:0]        granted_slot,
    output logic                     contents_lost
);

    localparam int SW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = (SW > SLOT_W) ? SW : SLOT_W;

    logic [SW-1:0] link_mem [ENTRIES];
    logic          busy_mem [ENTRIES];

    logic [CW-1:0] fill_cnt_reg, fill_cnt_next;
    logic          reuse_reg, reuse_next;
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] tail_reg, tail_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic [SW-1:0] prev_reg, prev_next;
    logic          have_prev_reg, have_prev_next;
    logic [SW-1:0] clr_cnt_reg, clr_cnt_next;

    logic [SW-1:0] link_rd_reg;
    logic          busy_rd_reg;
    logic [SW-1:0] rd_addr;

    status_t       status_reg;
    logic [SLOT_W-1:0] granted_reg;
    logic          lost_reg;

    logic [XW-1:0] req_ext;
    logic [SW-1:0] mark_addr;
    logic          mark_in_range;
    logic [SW-1:0] fill_slot;
    logic [XW-1:0] fill_ext;
    logic [XW-1:0] cur_ext;
    logic          fill_first;

    logic          link_we;
    logic [SW-1:0] link_waddr;
    logic [SW-1:0] link_wdata;
    logic          busy_we;
    logic [SW-1:0] busy_waddr;
    logic          busy_wdata;

    assign req_ext       = XW'(slot_index);
    assign mark_addr     = req_ext[SW-1:0];
    assign mark_in_range = 32'(slot_index) < ENTRIES;
    assign fill_slot     = fill_cnt_reg[SW-1:0];
    assign fill_ext      = XW'(fill_slot);
    assign cur_ext       = XW'(cur_reg);
    assign fill_first    = (fill_cnt_reg == '0);

    assign stat.clear_done  = (clr_cnt_reg == SW'(ENTRIES - 1));
    assign stat.fill_left   = !reuse_reg && (fill_cnt_reg != CW'(ENTRIES));
    assign stat.cur_free    = !busy_rd_reg;
    assign stat.cur_is_tail = (cur_reg == tail_reg);

    // The walk follows the link just read, so the next address comes
    // straight from the registered read data.
    assign rd_addr = cmd.walk_step ? link_rd_reg : head_reg;

    always_comb
    begin
        link_we    = 1'b0;
        link_waddr = tail_reg;
        link_wdata = cur_reg;
        if (cmd.fill_grant && !fill_first)
        begin
            link_we    = 1'b1;
            link_waddr = tail_reg;
            link_wdata = fill_slot;
        end
        else if (cmd.unlink && have_prev_reg)
        begin
            link_we    = 1'b1;
            link_waddr = prev_reg;
            link_wdata = link_rd_reg;
        end
        else if (cmd.append)
        begin
            link_we    = 1'b1;
            link_waddr = tail_reg;
            link_wdata = cur_reg;
        end
    end

    always_comb
    begin
        busy_we    = 1'b0;
        busy_waddr = clr_cnt_reg;
        busy_wdata = 1'b0;
        if (cmd.clr_step)
        begin
            busy_we = 1'b1;
        end
        else if (cmd.mark_wr && mark_in_range)
        begin
            busy_we    = 1'b1;
            busy_waddr = mark_addr;
            busy_wdata = busy_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (busy_we)
        begin
            busy_mem[busy_waddr] <= busy_wdata;
        end
        link_rd_reg <= link_mem[rd_addr];
        busy_rd_reg <= busy_mem[rd_addr];
    end

    always_comb
    begin
        fill_cnt_next  = fill_cnt_reg;
        reuse_next     = reuse_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        clr_cnt_next   = clr_cnt_reg;

        if (cmd.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
        if (cmd.fill_grant)
        begin
            fill_cnt_next = fill_cnt_reg + 1'b1;
            if (fill_first)
            begin
                head_next = '0;
                tail_next = '0;
            end
            else
            begin
                tail_next = fill_slot;
            end
        end
        if (cmd.walk_start)
        begin
            reuse_next     = 1'b1;
            cur_next       = head_reg;
            have_prev_next = 1'b0;
        end
        if (cmd.walk_step)
        begin
            prev_next      = cur_reg;
            have_prev_next = 1'b1;
            cur_next       = link_rd_reg;
        end
        if (cmd.unlink && !have_prev_reg)
        begin
            head_next = link_rd_reg;
        end
        if (cmd.append)
        begin
            tail_next = cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg  <= '0;
            reuse_reg     <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            fill_cnt_reg  <= fill_cnt_next;
            reuse_reg     <= reuse_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mark_wr)
        begin
            status_reg  <= STATUS_MARK_SET;
            granted_reg <= '0;
            lost_reg    <= 1'b0;
        end
        else if (cmd.fill_grant)
        begin
            status_reg  <= STATUS_GRANTED;
            granted_reg <= fill_ext[SLOT_W-1:0];
            lost_reg    <= 1'b0;
        end
        else if (cmd.load_grant)
        begin
            status_reg  <= STATUS_GRANTED;
            granted_reg <= cur_ext[SLOT_W-1:0];
            lost_reg    <= 1'b1;
        end
        else if (cmd.load_fail)
        begin
            status_reg  <= STATUS_NONE_FREE;
            granted_reg <= '0;
            lost_reg    <= 1'b0;
        end
    end

    assign status        = status_reg;
    assign granted_slot  = granted_reg;
    assign contents_lost = lost_reg;

endmodule
`default_nettype wire

>>> rtl/ftrsa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slot allocator controller
// Sequences the busy mark clearing pass, the mark and fill-mode requests
// and the reuse walk, and owns the response valid flag.
// ----------------------------------------------------------------------------
module ftrsa_ctrl import ftrsa_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    input  wire logic     req_kind,
    output logic          req_ready,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_APPEND
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   accept;
    logic   load;

    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_ready && req_valid;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd        = '0;
        load       = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_kind == KIND_MARK)
                    begin
                        cmd.mark_wr = 1'b1;
                        load        = 1'b1;
                    end
                    else if (stat.fill_left)
                    begin
                        cmd.fill_grant = 1'b1;
                        load           = 1'b1;
                    end
                    else
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (stat.cur_free && stat.cur_is_tail)
                begin
                    cmd.load_grant = 1'b1;
                    load           = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (stat.cur_free)
                begin
                    cmd.unlink = 1'b1;
                    state_next = ST_APPEND;
                end
                else if (stat.cur_is_tail)
                begin
                    cmd.load_fail = 1'b1;
                    load          = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_APPEND:
            begin
                cmd.append     = 1'b1;
                cmd.load_grant = 1'b1;
                load           = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        rsp_valid_next = load || (rsp_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule
`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Fill-then-reuse slot allocator testbench
// Drives allocation and busy mark words into the allocator and checks every
// response word against a predictor that keeps its own copy of the slot list.
// The sender works in bursts and the receiver stalls on its own pattern. One
// phase holds the receiver off for a long stretch so that the block stalls requests.
// ----------------------------------------------------------------------------
module tb;
    import ftrsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = 64;

    // Upper bound on the wait for the slowest response: a full walk of the
    // list plus the relink, with a little margin.
    localparam int WORD_LATENCY = ENTRIES + 4;

    // One expected response word.
    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic              lost;
    } grant_word_t;

    logic clk;
    logic rst_n;

    ftrsa_req_if req_ch ();
    ftrsa_rsp_if rsp_ch ();

    fill_then_reuse_slot_allocator #(
        .ENTRIES (ENTRIES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predicted state of the allocator: how many slots the fill phase has
    // handed out, whether it has moved to reuse, the two ends of the list,
    // the links between slots and the busy marks.
    logic [6:0]        alloc_count;
    logic              in_reuse;
    logic [SLOT_W-1:0] list_head;
    logic [SLOT_W-1:0] list_tail;
    logic [SLOT_W-1:0] link_of [ENTRIES];
    logic              mark_of [ENTRIES];

    // Response words still owed by the block, oldest first.
    grant_word_t pending_grants [$];

    // The expectation of the word that was accepted last, so that a test can
    // follow a grant with a busy mark on the slot it got.
    grant_word_t last_word;

    int fail_count;

    // Sender pacing: words left in the current burst, and a switch that
    // turns the gaps off for whole stretches.
    int burst_left;
    bit no_idle;

    // A request to the receiver to hold off for this many cycles.
    int hold_len;

    // ------------------------------------------------------------------------
    // Clock and timeout.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The timeout lies several times beyond the slowest run.
    initial
    begin
        #3000000;
        $display("fill_then_reuse_slot_allocator regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Failure reporting. Every failure prints one line and is counted.
    // ------------------------------------------------------------------------
    task automatic note_failure(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // ------------------------------------------------------------------------
    // Predictor. Applies one accepted word to the predicted state and returns
    // the response word that it must cause.
    // ------------------------------------------------------------------------
    function automatic grant_word_t grant_for_word(input logic kind,
                                                   input logic [SLOT_W-1:0] idx,
                                                   input logic bv);
        grant_word_t       w;
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] prev;
        logic [SLOT_W-1:0] succ;
        logic              have_prev;
        logic              done;
        int                n;

        w.status = STATUS_GRANTED;
        w.slot   = '0;
        w.lost   = 1'b0;

        // A busy mark word only writes the mark; an index beyond the slot
        // range changes nothing but is still answered.
        if (kind == KIND_MARK)
        begin
            if (int'(idx) < ENTRIES)
                mark_of[idx] = bv;
            w.status = STATUS_MARK_SET;
            return w;
        end

        // Fill phase: hand out the next unused slot and put it at the tail.
        if (!in_reuse)
        begin
            if (int'(alloc_count) < ENTRIES)
            begin
                w.slot = alloc_count[SLOT_W-1:0];
                if (alloc_count == 0)
                begin
                    list_head = '0;
                    list_tail = '0;
                end
                else
                begin
                    link_of[list_tail] = w.slot;
                    list_tail          = w.slot;
                end
                alloc_count = alloc_count + 7'd1;
                return w;
            end
            // The allocation that finds every slot used is served by the
            // walk below, in the same word.
            in_reuse = 1'b1;
        end

        // Reuse phase: walk from the head to the first slot that is not busy.
        w.status  = STATUS_NONE_FREE;
        cur       = list_head;
        prev      = '0;
        have_prev = 1'b0;
        done      = 1'b0;
        for (n = 0; n < ENTRIES && !done; n++)
        begin
            if (!mark_of[cur])
            begin
                // A free tail stays where it is; anything else is unlinked
                // and moved behind the tail, moving the head on if needed.
                if (cur != list_tail)
                begin
                    succ = link_of[cur];
                    if (have_prev)
                        link_of[prev] = succ;
                    else
                        list_head = succ;
                    link_of[list_tail] = cur;
                    list_tail          = cur;
                end
                w.status = STATUS_GRANTED;
                w.slot   = cur;
                w.lost   = 1'b1;
                done     = 1'b1;
            end
            else if (cur == list_tail)
            begin
                done = 1'b1;
            end
            else
            begin
                prev      = cur;
                have_prev = 1'b1;
                cur       = link_of[cur];
            end
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Called at a rising edge; returns at the rising edge at which
    // the word was accepted. Gaps are put in front of a word only when the
    // current burst has run out, so valid is never lowered and raised again
    // within one time step. The handshake is sampled at the falling edge,
    // where neither side is changing anything.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic kind,
                             input logic [SLOT_W-1:0] idx,
                             input logic bv);
        int gap;

        if (!no_idle && burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                              : $urandom_range(0, 4);
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left != 0)
            burst_left--;

        req_ch.valid      <= 1'b1;
        req_ch.kind       <= kind;
        req_ch.slot_index <= idx;
        req_ch.busy_value <= bv;

        @(negedge clk);
        while (!req_ch.ready)
            @(negedge clk);
        @(posedge clk);

        last_word = grant_for_word(kind, idx, bv);
        pending_grants.push_back(last_word);
    endtask

    // Brings every busy mark to the same value, sending a word only for the
    // slots whose mark differs.
    task automatic set_all_marks(input logic value);
        int s;

        for (s = 0; s < ENTRIES; s++)
            if (mark_of[s] != value)
                send_word(KIND_MARK, SLOT_W'(s), value);
    endtask

    // ------------------------------------------------------------------------
    // Receiver. Works in segments of random length, each with its own stall
    // pattern: always ready, a coin toss, mostly stalled, or ready in a regular
    // rhythm set by a phase counter. A hold-off request from a test overrides
    // the pattern and is counted down here, one cycle at a time.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int mode;
        int seg;
        int n;
        int phase;

        rsp_ch.ready <= 1'b0;
        phase = 0;
        @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 4);
            seg  = $urandom_range(1, 64);
            repeat (seg)
            begin
                if (hold_len != 0)
                begin
                    n        = hold_len;
                    hold_len = 0;
                    repeat (n)
                    begin
                        rsp_ch.ready <= 1'b0;
                        @(posedge clk);
                    end
                end
                case (mode)
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    3:       rsp_ch.ready <= (phase % 3 == 0);
                    default: rsp_ch.ready <= 1'b1;
                endcase
                phase++;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response checker. A response word is taken at the rising edge after a
    // falling edge at which valid and ready are both high, and is compared
    // field by field with the oldest expectation.
    // ------------------------------------------------------------------------
    initial
    begin : response_checker
        grant_word_t want;

        forever
        begin
            @(negedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_grants.size() == 0)
                begin
                    note_failure($sformatf("response with nothing expected, status %0d",
                                           rsp_ch.status));
                end
                else
                begin
                    want = pending_grants.pop_front();
                    if (rsp_ch.status !== want.status)
                        note_failure($sformatf("status got %0d want %0d",
                                               rsp_ch.status, want.status));
                    if (rsp_ch.granted_slot !== want.slot)
                        note_failure($sformatf("granted_slot got %0d want %0d",
                                               rsp_ch.granted_slot, want.slot));
                    if (rsp_ch.contents_lost !== want.lost)
                        note_failure($sformatf("contents_lost got %0d want %0d",
                                               rsp_ch.contents_lost, want.lost));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Busy mark words on the lowest and highest slots and on alternating bit
    // patterns, before anything has been allocated.
    task automatic test_mark_extremes();
        send_word(KIND_MARK, 6'd0, 1'b1);
        send_word(KIND_MARK, 6'd63, 1'b1);
        send_word(KIND_MARK, 6'd63, 1'b0);
        send_word(KIND_MARK, 6'd0, 1'b0);
        send_word(KIND_MARK, 6'd21, 1'b1);
        send_word(KIND_MARK, 6'd42, 1'b0);
        send_word(KIND_MARK, 6'd21, 1'b0);
    endtask

    // Allocates until every slot has been handed out once. The first word
    // carries all-ones in the fields that an allocation ignores; after that
    // those fields are random, and allocations are mixed with busy marks the
    // way a user would set them: on the slot just granted, or anywhere.
    task automatic test_fill_sequence();
        send_word(KIND_ALLOC, 6'd63, 1'b1);
        while (int'(alloc_count) < ENTRIES)
        begin
            send_word(KIND_ALLOC, SLOT_W'($urandom_range(0, ENTRIES - 1)),
                      1'($urandom_range(0, 1)));
            if ($urandom_range(0, 1) == 1)
                send_word(KIND_MARK, last_word.slot, 1'b1);
            if ($urandom_range(0, 3) == 0)
                send_word(KIND_MARK, SLOT_W'($urandom_range(0, ENTRIES - 1)),
                          1'($urandom_range(0, 1)));
        end
    endtask

    // The corners of the reuse walk, each set up through the busy marks.
    task automatic test_reuse_corners();
        // With every mark clear, the allocation that finds the fill used up
        // switches to reuse and takes the head; so does the next one.
        set_all_marks(1'b0);
        send_word(KIND_ALLOC, 6'd0, 1'b0);
        send_word(KIND_ALLOC, 6'd0, 1'b0);

        // A busy head makes the walk take the slot behind it, which must be
        // unlinked from the middle of the list.
        send_word(KIND_MARK, list_head, 1'b1);
        send_word(KIND_ALLOC, 6'd0, 1'b0);

        // Nothing free anywhere: the full walk ends at the tail in failure.
        set_all_marks(1'b1);
        send_word(KIND_ALLOC, 6'd0, 1'b0);

        // Only the tail is free: the longest walk, and the list stays put,
        // so a second allocation gets the same slot again.
        send_word(KIND_MARK, list_tail, 1'b0);
        send_word(KIND_ALLOC, 6'd0, 1'b0);
        send_word(KIND_ALLOC, 6'd0, 1'b0);

        set_all_marks(1'b0);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words back to back, so that the response register fills and
    // the block has to stall the request channel.
    task automatic test_backpressure();
        int i;

        no_idle  = 1'b1;
        hold_len = 400;
        for (i = 0; i < 16; i++)
        begin
            if (i % 2 == 0)
                send_word(KIND_ALLOC, SLOT_W'($urandom_range(0, ENTRIES - 1)),
                          1'($urandom_range(0, 1)));
            else
                send_word(KIND_MARK, SLOT_W'($urandom_range(0, ENTRIES - 1)),
                          1'($urandom_range(0, 1)));
        end
        no_idle = 1'b0;
    endtask

    // Random traffic in phases. Each phase has its own density of busy marks,
    // from almost none, where walks are short, to almost all, where walks run
    // the length of the list and often fail. A granted allocation is followed,
    // at the phase's density, by a mark on the slot it got, as a user of the slot would do.
    task automatic test_random_traffic(input int count);
        int sent;
        int busy_pct;
        int phase_left;

        sent       = 0;
        busy_pct   = 0;
        phase_left = 0;
        while (sent < count)
        begin
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       busy_pct = 5;
                    1:       busy_pct = 40;
                    2:       busy_pct = 80;
                    default: busy_pct = 97;
                endcase
                phase_left = $urandom_range(40, 160);
                no_idle    = ($urandom_range(0, 3) == 0);
            end
            phase_left--;

            if ($urandom_range(0, 99) < 45)
            begin
                send_word(KIND_ALLOC, SLOT_W'($urandom_range(0, ENTRIES - 1)),
                          1'($urandom_range(0, 1)));
                sent++;
                if (last_word.status == STATUS_GRANTED &&
                    $urandom_range(0, 99) < busy_pct)
                begin
                    send_word(KIND_MARK, last_word.slot, 1'b1);
                    sent++;
                end
            end
            else
            begin
                send_word(KIND_MARK, SLOT_W'($urandom_range(0, ENTRIES - 1)),
                          ($urandom_range(0, 99) < busy_pct));
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        int s;
        int drain;

        fail_count  = 0;
        burst_left  = 0;
        no_idle     = 1'b0;
        hold_len    = 0;
        alloc_count = '0;
        in_reuse    = 1'b0;
        list_head   = '0;
        list_tail   = '0;
        last_word   = '0;
        for (s = 0; s < ENTRIES; s++)
        begin
            link_of[s] = '0;
            mark_of[s] = 1'b0;
        end

        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.kind       <= KIND_ALLOC;
        req_ch.slot_index <= '0;
        req_ch.busy_value <= 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        // The clearing pass after reset keeps req.ready low; the first word
        // simply waits for it.
        @(posedge clk);

        test_mark_extremes();
        test_fill_sequence();
        test_reuse_corners();
        test_backpressure();
        test_random_traffic(1650);

        req_ch.valid <= 1'b0;

        // Wait for the last responses, then a little longer for any word the
        // block should not have sent.
        drain = 0;
        while (pending_grants.size() != 0 && drain < 100 * WORD_LATENCY)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (WORD_LATENCY) @(posedge clk);
        if (pending_grants.size() != 0)
            note_failure($sformatf("%0d responses never arrived",
                                   pending_grants.size()));

        if (fail_count == 0)
            $display("fill_then_reuse_slot_allocator regression: pass");
        else
            $display("fill_then_reuse_slot_allocator regression: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/ftrsa_pkg.sv
rtl/ftrsa_req_if.sv
rtl/ftrsa_rsp_if.sv
rtl/ftrsa_dp.sv
rtl/ftrsa_ctrl.sv
rtl/fill_then_reuse_slot_allocator.sv
tb/tb.sv
